>>> rtl/pcrc_pkg.sv
// Package for the parametric CRC engine.
// Holds the width codes, register indexes, config struct and bit helpers.
// No dependencies.
package pcrc_pkg;

  typedef logic [31:0] crc_word_t;

  localparam int CFG_INDEX_BITS = 3;

  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_MODE  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POLYNOMIAL  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INIT_VALUE  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_XOR_OUT     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REFLECT_IN  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REFLECT_OUT = 3'd5;

  typedef struct packed {
    logic [1:0] width_mode;
    crc_word_t  polynomial;
    logic       reflect_in;
  } crc_cfg_t;

  function automatic crc_word_t width_mask(input logic [1:0] mode);
    crc_word_t m;
    case (mode)
      WIDTH_8:  m = 32'h0000_00FF;
      WIDTH_16: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

  function automatic crc_word_t reverse32(input crc_word_t v);
    crc_word_t r;
    for (int k = 0; k < 32; k++) begin
      r[k] = v[31-k];
    end
    return r;
  endfunction

endpackage

>>> rtl/pcrc_byte_step.sv
// One-byte CRC update: input reflection, byte merge and eight shift/XOR steps.
// Depends on pcrc_pkg.
module pcrc_byte_step (
  input  pcrc_pkg::crc_cfg_t  cfg,
  input  pcrc_pkg::crc_word_t crc_in,
  input  logic [7:0]          data_byte,
  input  logic                has_data,
  output pcrc_pkg::crc_word_t crc_out
);
  import pcrc_pkg::*;

  always_comb begin
    crc_word_t  mask;
    crc_word_t  poly;
    crc_word_t  merged;
    crc_word_t  crc;
    logic [7:0] b;
    logic       top;
    mask = width_mask(cfg.width_mode);
    poly = cfg.polynomial & mask;
    b    = cfg.reflect_in ? reverse8(data_byte) : data_byte;
    unique case (cfg.width_mode)
      WIDTH_8:  merged = {24'd0, b};
      WIDTH_16: merged = {16'd0, b, 8'd0};
      default:  merged = {b, 24'd0};
    endcase
    crc = (crc_in & mask) ^ merged;
    for (int k = 0; k < 8; k++) begin
      unique case (cfg.width_mode)
        WIDTH_8:  top = crc[7];
        WIDTH_16: top = crc[15];
        default:  top = crc[31];
      endcase
      crc = ((crc << 1) ^ (top ? poly : 32'd0)) & mask;
    end
    crc_out = has_data ? crc : (crc_in & mask);
  end

endmodule

>>> rtl/parametric_crc_engine.sv
// Byte-serial CRC engine at 8, 16 or 32 bits with programmable polynomial,
// init value, final XOR and reflection. Each accepted item is registered,
// then folded into the running CRC by an eight-step shift/XOR network when
// it advances out of the input register; an item marked last loads the
// result register as it advances. One item per cycle is sustained: the loop
// through the running CRC register is the only feedback path, and a held
// result stalls the input only when a further last item is waiting.
// Depends on pcrc_pkg and pcrc_byte_step.
module parametric_crc_engine (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            data_byte,
  input  logic                                  has_data,
  input  logic                                  is_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [31:0]                           crc_value,
  input  logic                                  cfg_write,
  input  logic [pcrc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [31:0]                           cfg_data
);
  import pcrc_pkg::*;

  logic [1:0] width_mode;
  crc_word_t  polynomial;
  crc_word_t  init_value;
  crc_word_t  xor_out;
  logic       reflect_in;
  logic       reflect_out;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_has_data;
  logic       s1_last;

  crc_word_t  running_crc;
  logic       message_open;

  crc_cfg_t   step_cfg;
  crc_word_t  mask;
  crc_word_t  crc_start;
  crc_word_t  crc_next;
  crc_word_t  crc_final;
  logic       out_free;
  logic       advance;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      width_mode  <= WIDTH_32;
      polynomial  <= 32'h04C1_1DB7;
      init_value  <= 32'hFFFF_FFFF;
      xor_out     <= 32'hFFFF_FFFF;
      reflect_in  <= 1'b1;
      reflect_out <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WIDTH_MODE:  width_mode  <= cfg_data[1:0];
        REG_POLYNOMIAL:  polynomial  <= cfg_data;
        REG_INIT_VALUE:  init_value  <= cfg_data;
        REG_XOR_OUT:     xor_out     <= cfg_data;
        REG_REFLECT_IN:  reflect_in  <= cfg_data[0];
        REG_REFLECT_OUT: reflect_out <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && (!s1_last || out_free);
  assign in_stall = rst || (s1_valid && !advance);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte     <= data_byte;
      s1_has_data <= has_data;
      s1_last     <= is_last;
    end
  end

  assign mask      = width_mask(width_mode);
  assign crc_start = message_open ? running_crc : (init_value & mask);

  assign step_cfg.width_mode = width_mode;
  assign step_cfg.polynomial = polynomial;
  assign step_cfg.reflect_in = reflect_in;

  pcrc_byte_step u_step (
    .cfg       (step_cfg),
    .crc_in    (crc_start),
    .data_byte (s1_byte),
    .has_data  (s1_has_data),
    .crc_out   (crc_next)
  );

  always_comb begin
    crc_word_t r;
    r = crc_next;
    if (reflect_out) begin
      unique case (width_mode)
        WIDTH_8:  r = reverse32(crc_next) >> 24;
        WIDTH_16: r = reverse32(crc_next) >> 16;
        default:  r = reverse32(crc_next);
      endcase
    end
    crc_final = (r ^ xor_out) & mask;
  end

  // running state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc  <= '0;
      message_open <= 1'b0;
    end else if (advance) begin
      running_crc  <= crc_next;
      message_open <= !s1_last;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      crc_value <= crc_final;
    end
  end

endmodule

>>> rtl/pcrc_checker.sv
// Port-level checker for parametric_crc_engine, attached with bind.
// Depends on pcrc_pkg.
module pcrc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [31:0]                         crc_value,
  input logic                                cfg_write,
  input logic [pcrc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input logic [31:0]                         cfg_data
);
  import pcrc_pkg::*;

  logic [1:0] mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= WIDTH_32;
    end else if (cfg_write && cfg_index == REG_WIDTH_MODE) begin
      mode <= cfg_data[1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(crc_value))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching input transfer");

  a_narrow_upper: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mode == WIDTH_8 || mode == WIDTH_16) |->
      crc_value[31:16] == 16'd0 && (mode == WIDTH_16 || crc_value[15:8] == 8'd0))
    else $error("bits above the CRC width are set");

endmodule

bind parametric_crc_engine pcrc_checker u_pcrc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .crc_value (crc_value),
  .cfg_write (cfg_write),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
